// ===== src/bstat_pkg.sv =====
`default_nettype none
package bstat_pkg;

	localparam int unsigned VAL_W    = 13;
	localparam int unsigned STAT_W   = 17;
	localparam int unsigned TIME_W   = 32;
	localparam int unsigned ID_W     = 8;
	localparam int unsigned KIND_W   = 2;
	localparam logic [VAL_W-1:0] VALUE_SAT = 13'd8000;

	typedef logic [KIND_W-1:0] kind_t;

	localparam kind_t KIND_MAX    = 2'd0;
	localparam kind_t KIND_MIN    = 2'd1;
	localparam kind_t KIND_MEAN   = 2'd2;
	localparam kind_t KIND_MEDIAN = 2'd3;

endpackage
`default_nettype wire

// ===== src/batch_min_max_mean_median.sv =====
`default_nettype none
// Batch statistics of one sensor. While busy is low, each cycle with start high
// loads one sample item into the on-chip sample memory, so a batch streams in at
// one item per cycle. On the item marked batch_end, busy rises and the block
// computes the mean with a restoring divider (a load step, one quotient bit per
// cycle, and a closing step) and the median by a bit-by-bit rank search that
// sweeps the sample memory once per value bit for each rank, run once for an
// odd batch size and twice for an even one, limited by the single read port of
// the memory. Then the four results (max, min, mean, median) appear one after
// another in that order, each marked by result_valid for exactly one cycle;
// the receiver cannot stall them. Samples beyond MAX_SAMPLES in a batch are
// ignored, but their batch_end mark still closes the batch.
module batch_min_max_mean_median #(
	parameter int unsigned MAX_SAMPLES = 4096
) (
	input  wire                                   clk,
	input  wire                                   arst_n,
	input  wire                                   start,
	output logic                                  busy,
	input  wire  [bstat_pkg::ID_W-1:0]            sensor_id,
	input  wire  [bstat_pkg::VAL_W-1:0]           sample_value,
	input  wire  [bstat_pkg::TIME_W-1:0]          sample_time,
	input  wire                                   batch_end,
	output logic                                  result_valid,
	output logic [bstat_pkg::ID_W-1:0]            result_sensor,
	output logic [bstat_pkg::KIND_W-1:0]          stat_kind,
	output logic [bstat_pkg::TIME_W-1:0]          stat_time,
	output logic [bstat_pkg::STAT_W-1:0]          stat_value,
	output logic                                  stat_last
);
	import bstat_pkg::*;

	localparam int unsigned CW   = $clog2(MAX_SAMPLES + 1);
	localparam int unsigned AW   = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
	localparam int unsigned SW   = CW + VAL_W;
	localparam int unsigned NW   = SW + 5;
	localparam int unsigned DW   = CW + 1;
	localparam int unsigned DCW  = $clog2(NW + 2);
	localparam int unsigned BW   = 4;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DIV  = 2'd1;
	localparam logic [1:0] ST_SEL  = 2'd2;
	localparam logic [1:0] ST_EMIT = 2'd3;

	logic [1:0]        state_q;
	logic [CW-1:0]     count_q;
	logic [SW-1:0]     sum_q;
	logic [VAL_W-1:0]  max_q, min_q;
	logic [TIME_W-1:0] max_time_q, min_time_q;
	logic [ID_W-1:0]   sensor_q;

	logic [NW-1:0]     num_q;
	logic [DW-1:0]     rem_q;
	logic [DW-1:0]     divisor_q;
	logic [DCW-1:0]    div_cnt_q;
	logic [STAT_W-1:0] mean_q;

	logic [CW:0]       addr_q;
	logic [CW-1:0]     c0_q;
	logic [CW-1:0]     k_q;
	logic [VAL_W-1:0]  prefix_q;
	logic [BW-1:0]     bit_q;
	logic              phase_q;
	logic [VAL_W-1:0]  val_a_q;
	logic [STAT_W-1:0] median_q;
	logic [1:0]        emit_q;

	logic [VAL_W-1:0]  mem [MAX_SAMPLES];
	logic [VAL_W-1:0]  rd_q;

	logic [VAL_W-1:0]  v_sat;
	logic              accept, store;
	logic [DW:0]       rem_try;
	logic              rem_ge;
	logic [VAL_W:0]    hi_mask_w;
	logic [VAL_W-1:0]  hi_mask;
	logic              match;
	logic [CW-1:0]     c0_next;
	logic              take_one;
	logic [VAL_W-1:0]  prefix_next;
	logic              pass_end;

	assign v_sat  = (sample_value > VALUE_SAT) ? VALUE_SAT : sample_value;
	assign accept = start && !busy;
	assign store  = accept && (count_q < CW'(MAX_SAMPLES));
	assign busy   = (state_q != ST_IDLE);

	// Restoring division step.
	assign rem_try = {rem_q, num_q[NW-1]};
	assign rem_ge  = (rem_try >= {1'b0, divisor_q});

	// Rank search: count samples that share the known upper bits and hold 0 here.
	assign hi_mask_w   = {1'b1, {VAL_W{1'b1}}} << (bit_q + BW'(1));
	assign hi_mask     = hi_mask_w[VAL_W-1:0];
	assign match       = (addr_q != '0) && ((((rd_q ^ prefix_q) & hi_mask) == '0)
		&& !rd_q[bit_q]);
	assign c0_next     = c0_q + CW'(match);
	assign take_one    = (k_q >= c0_next);
	assign prefix_next = prefix_q | (VAL_W'(take_one) << bit_q);
	assign pass_end    = (addr_q == {1'b0, count_q});

	always_ff @(posedge clk) begin
		if (store)
			mem[count_q[AW-1:0]] <= v_sat;
		rd_q <= mem[addr_q[AW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			count_q    <= '0;
			sum_q      <= '0;
			max_q      <= '0;
			min_q      <= '0;
			max_time_q <= '0;
			min_time_q <= '0;
			sensor_q   <= '0;
			div_cnt_q  <= '0;
			addr_q     <= '0;
			c0_q       <= '0;
			k_q        <= '0;
			prefix_q   <= '0;
			bit_q      <= '0;
			phase_q    <= 1'b0;
			emit_q     <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (store) begin
						count_q <= count_q + CW'(1);
						sum_q   <= sum_q + SW'(v_sat);
						if (count_q == '0) begin
							sensor_q   <= sensor_id;
							max_q      <= v_sat;
							min_q      <= v_sat;
							max_time_q <= sample_time;
							min_time_q <= sample_time;
						end else begin
							if (v_sat > max_q) begin
								max_q      <= v_sat;
								max_time_q <= sample_time;
							end
							if (v_sat < min_q) begin
								min_q      <= v_sat;
								min_time_q <= sample_time;
							end
						end
					end
					if (accept && batch_end) begin
						state_q   <= ST_DIV;
						div_cnt_q <= '0;
					end
				end
				ST_DIV: begin
					if (div_cnt_q == DCW'(NW + 1)) begin
						state_q  <= ST_SEL;
						addr_q   <= '0;
						c0_q     <= '0;
						prefix_q <= '0;
						bit_q    <= BW'(VAL_W - 1);
						phase_q  <= 1'b0;
						k_q      <= (count_q >> 1) - CW'(!count_q[0]);
					end else begin
						div_cnt_q <= div_cnt_q + DCW'(1);
					end
				end
				ST_SEL: begin
					if (pass_end) begin
						addr_q <= '0;
						c0_q   <= '0;
						if (bit_q == '0) begin
							prefix_q <= '0;
							bit_q    <= BW'(VAL_W - 1);
							if (!phase_q && !count_q[0]) begin
								phase_q <= 1'b1;
								k_q     <= count_q >> 1;
							end else begin
								state_q <= ST_EMIT;
								emit_q  <= '0;
							end
						end else begin
							if (take_one)
								k_q <= k_q - c0_next;
							prefix_q <= prefix_next;
							bit_q    <= bit_q - BW'(1);
						end
					end else begin
						c0_q   <= c0_next;
						addr_q <= addr_q + (CW+1)'(1);
					end
				end
				ST_EMIT: begin
					emit_q <= emit_q + 2'd1;
					if (emit_q == 2'd3) begin
						state_q    <= ST_IDLE;
						count_q    <= '0;
						sum_q      <= '0;
						max_q      <= '0;
						min_q      <= '0;
						max_time_q <= '0;
						min_time_q <= '0;
						sensor_q   <= '0;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers of the divider and the rank search.
	always_ff @(posedge clk) begin
		if (state_q == ST_DIV) begin
			// The first divider cycle loads the totals that include the closing item.
			if (div_cnt_q == '0) begin
				num_q     <= (NW'(sum_q) << 4) + (NW'(sum_q) << 2) + NW'(count_q);
				divisor_q <= {count_q, 1'b0};
				rem_q     <= '0;
			end else if (div_cnt_q != DCW'(NW + 1)) begin
				num_q <= {num_q[NW-2:0], rem_ge};
				rem_q <= rem_ge ? DW'(rem_try - {1'b0, divisor_q}) : rem_try[DW-1:0];
			end
			mean_q <= num_q[STAT_W-1:0];
		end
		if (state_q == ST_SEL && pass_end && bit_q == '0) begin
			if (!phase_q) begin
				val_a_q  <= prefix_next;
				median_q <= STAT_W'(prefix_next) * STAT_W'(10);
			end else begin
				median_q <= (STAT_W'(val_a_q) + STAT_W'(prefix_next)) * STAT_W'(5);
			end
		end
	end

	always_comb begin
		result_valid  = (state_q == ST_EMIT);
		result_sensor = sensor_q;
		stat_kind     = emit_q;
		stat_last     = (emit_q == KIND_MEDIAN);
		case (emit_q)
			KIND_MAX: begin
				stat_time  = max_time_q;
				stat_value = STAT_W'(max_q) * STAT_W'(10);
			end
			KIND_MIN: begin
				stat_time  = min_time_q;
				stat_value = STAT_W'(min_q) * STAT_W'(10);
			end
			KIND_MEAN: begin
				stat_time  = '0;
				stat_value = mean_q;
			end
			default: begin
				stat_time  = '0;
				stat_value = median_q;
			end
		endcase
	end

endmodule
`default_nettype wire
